[rtl/ecgbd_pkg.sv]
// ----------------------------------------------------------------------------
// ecgbd_pkg
// Shared widths, constants and register indexes for the ECG beat detector.
// ----------------------------------------------------------------------------
package ecgbd_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned BASE_W     = 28;
  localparam int unsigned DIFF_W     = 29;
  localparam int unsigned FILT_W     = 21;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned DISP_W     = 12;
  localparam int unsigned SLOT_OUT_W = 8;

  localparam int unsigned THR_W      = 13;
  localparam int unsigned REFR_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned WEIGHT_W   = 11;
  localparam logic [WEIGHT_W-1:0] WEIGHT_Q16 = 11'd1966;
  localparam int unsigned PROD_W     = DIFF_W + WEIGHT_W;
  localparam int unsigned ACC_W      = PROD_W + 1;

  // rate division: 60000 / interval, interval narrowed to 16 bits
  localparam int unsigned RATE_DVD_W = 16;
  localparam int unsigned RATE_DVS_W = 16;
  localparam logic [RATE_DVD_W-1:0] RATE_NUM = 16'd60000;

  // display division: 2*t / 125
  localparam int unsigned DISP_T_W   = 22;
  localparam int unsigned DISP_DVD_W = 19;
  localparam int unsigned DISP_DVS_W = 7;
  localparam logic [DISP_DVS_W-1:0] DISP_DIV = 7'd125;
  localparam logic signed [DISP_T_W-1:0] DISP_OFFSET = 22'sd128000;
  localparam logic [DISP_T_W-1:0] DISP_SAT_T = 22'd256000;
  localparam logic [DISP_W-1:0] DISP_MAX = 12'd4095;

  localparam logic [CFG_ADDR_W-1:0] REG_BEAT_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY_MS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_RATE_BPM   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RATE_BPM   = 2'd3;

  localparam logic [THR_W-1:0]  THR_RST     = 13'h1F38;  // -200
  localparam logic [REFR_W-1:0] REFR_RST    = 16'd400;
  localparam logic [RATE_W-1:0] MIN_RATE_RST = 8'd40;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 8'd160;

endpackage

[rtl/ecgbd_div.sv]
// ----------------------------------------------------------------------------
// ecgbd_div
// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// ----------------------------------------------------------------------------
module ecgbd_div
  import ecgbd_pkg::*;
#(
  parameter int unsigned DVD_W = RATE_DVD_W,
  parameter int unsigned DVS_W = RATE_DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem_r, q_r[DVD_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      q_nxt    = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      q_nxt    = {q_r[DVD_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

[rtl/ecg_baseline_beat_rate_detector_top.sv]
// ----------------------------------------------------------------------------
// ecg_baseline_beat_rate_detector_top
// Baseline-tracking ECG beat detector with rate and display sample output.
// ----------------------------------------------------------------------------
// Each sample passes the states DIFF, MUL, UPD, FILT, DSTART, DIV and OUT;
//   the 11-step serial weight multiply and the 19-step display divider
//   (rate divider runs alongside) take the longest; a sample is taken only in IDLE.
// A new sample is accepted while the previous result waits on the output.
// Reset (rst_n low, synchronous) restores register defaults, seeds the
//   baseline from the next sample and clears rate, slot and wrap state.
// ----------------------------------------------------------------------------
module ecg_baseline_beat_rate_detector_top
  import ecgbd_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // adc_sample[11:0], time_ms[43:12]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // filtered_value[20:0], beat_detected[21], heart_rate_bpm[29:22],
  // display_sample[41:30], slot_index[49:42], buffer_filled[50]
  output logic [55:0]           out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned MCNT_W  = $clog2(WEIGHT_W + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_FILT   = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]              state_r, state_nxt;

  logic [THR_W-1:0]        thr_r;
  logic [REFR_W-1:0]       refr_r;
  logic [RATE_W-1:0]       min_rate_r;
  logic [RATE_W-1:0]       max_rate_r;

  logic [SAMPLE_W-1:0]     sample_r;
  logic [TIME_W-1:0]       time_r;
  logic [BASE_W-1:0]       base_r;
  logic                    first_pending_r;
  logic [TIME_W-1:0]       last_cross_r;
  logic [RATE_W-1:0]       held_rate_r;
  logic [SLOT_W-1:0]       slot_r;
  logic                    wrapped_r;

  logic signed [PROD_W-1:0] diff_sh_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [WEIGHT_W-1:0]      w_sr_r;
  logic [MCNT_W-1:0]        mcnt_r;

  logic signed [FILT_W-1:0] filt_r;
  logic                     cross_r;
  logic [RATE_DVS_W-1:0]    interval_lo_r;
  logic                     interval_big_r;
  logic                     disp_zero_r;
  logic                     disp_sat_r;
  logic [DISP_DVD_W-1:0]    disp_dvd_r;

  logic                     out_valid_r;
  logic [55:0]              out_data_r;

  logic                     in_fire;
  logic                     out_load;
  logic                     div_start;
  logic                     rate_busy, disp_busy;
  logic [RATE_DVD_W-1:0]    rate_q;
  logic [DISP_DVD_W-1:0]    disp_q;

  logic [BASE_W-1:0]        target;
  logic signed [DIFF_W-1:0] diff_now;
  logic signed [ACC_W-1:0]  rounded;
  logic [BASE_W-1:0]        step;
  logic signed [FILT_W-1:0] filt_now;
  logic signed [FILT_W-1:0] thr_scaled;
  logic [TIME_W-1:0]        interval;
  logic signed [DISP_T_W-1:0] disp_t;
  logic                     rate_ok;
  logic [DISP_W-1:0]        disp_val;
  logic                     slot_last;
  logic                     wrapped_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign div_start = (state_r == S_DSTART);

  assign target     = {sample_r, 16'b0};
  assign diff_now   = $signed({1'b0, target}) - $signed({1'b0, base_r});
  assign rounded    = acc_r + ACC_W'(32768);
  assign step       = {{3{rounded[ACC_W-1]}}, rounded[ACC_W-1:16]};
  assign filt_now   = diff_now[DIFF_W-1:8];
  assign thr_scaled = {thr_r, 8'b0};
  assign interval   = time_r - last_cross_r;
  assign disp_t     = $signed({filt_now[FILT_W-1], filt_now}) + DISP_OFFSET;

  assign rate_ok = !interval_big_r
                   && (rate_q > {8'b0, min_rate_r})
                   && (rate_q < {8'b0, max_rate_r});
  assign disp_val = disp_zero_r ? '0 :
                    disp_sat_r  ? DISP_MAX : disp_q[DISP_W-1:0];
  assign slot_last   = (slot_r == SLOT_W'(RING_DEPTH - 1));
  assign wrapped_nxt = wrapped_r || slot_last;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL;
      S_MUL:    if (mcnt_r == MCNT_W'(1)) state_nxt = S_UPD;
      S_UPD:    state_nxt = S_FILT;
      S_FILT:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    if (!rate_busy && !disp_busy) state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      thr_r           <= THR_RST;
      refr_r          <= REFR_RST;
      min_rate_r      <= MIN_RATE_RST;
      max_rate_r      <= MAX_RATE_RST;
      base_r          <= '0;
      first_pending_r <= 1'b1;
      last_cross_r    <= '0;
      held_rate_r     <= '0;
      slot_r          <= '0;
      wrapped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_BEAT_THRESHOLD: thr_r      <= cfg_wdata[THR_W-1:0];
          REG_REFRACTORY_MS:  refr_r     <= cfg_wdata[REFR_W-1:0];
          REG_MIN_RATE_BPM:   min_rate_r <= cfg_wdata[RATE_W-1:0];
          REG_MAX_RATE_BPM:   max_rate_r <= cfg_wdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && first_pending_r) begin
        base_r          <= {in_tdata[SAMPLE_W-1:0], 16'b0};
        first_pending_r <= 1'b0;
      end
      if (state_r == S_UPD) base_r <= base_r + step;
      if (state_r == S_FILT && filt_now < thr_scaled && interval > {16'b0, refr_r})
        last_cross_r <= time_r;
      if (out_load) begin
        if (cross_r && rate_ok) held_rate_r <= rate_q[RATE_W-1:0];
        slot_r    <= slot_last ? '0 : slot_r + 1'b1;
        wrapped_r <= wrapped_nxt;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_tdata[SAMPLE_W-1:0];
      time_r   <= in_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
    end
    case (state_r)
      S_DIFF: begin
        diff_sh_r <= PROD_W'(diff_now);
        acc_r     <= '0;
        w_sr_r    <= WEIGHT_Q16;
        mcnt_r    <= MCNT_W'(WEIGHT_W);
      end
      S_MUL: begin
        if (w_sr_r[0]) acc_r <= acc_r + {diff_sh_r[PROD_W-1], diff_sh_r};
        diff_sh_r <= diff_sh_r <<< 1;
        w_sr_r    <= w_sr_r >> 1;
        mcnt_r    <= mcnt_r - 1'b1;
      end
      S_FILT: begin
        filt_r         <= filt_now;
        cross_r        <= (filt_now < thr_scaled) && (interval > {16'b0, refr_r});
        interval_lo_r  <= interval[RATE_DVS_W-1:0];
        interval_big_r <= (interval[TIME_W-1:RATE_DVS_W] != '0);
        disp_zero_r    <= disp_t[DISP_T_W-1] || (disp_t == '0);
        disp_sat_r     <= !disp_t[DISP_T_W-1] && (disp_t >= DISP_SAT_T);
        disp_dvd_r     <= {disp_t[DISP_DVD_W-2:0], 1'b0};
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {5'b0,
                     wrapped_nxt,
                     SLOT_OUT_W'(slot_r),
                     disp_val,
                     (cross_r && rate_ok) ? rate_q[RATE_W-1:0] : held_rate_r,
                     cross_r && rate_ok,
                     filt_r};
    end
  end

  ecgbd_div #(
    .DVD_W (RATE_DVD_W),
    .DVS_W (RATE_DVS_W)
  ) u_rate_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (RATE_NUM),
    .divisor  (interval_lo_r),
    .busy     (rate_busy),
    .quotient (rate_q)
  );

  ecgbd_div #(
    .DVD_W (DISP_DVD_W),
    .DVS_W (DISP_DVS_W)
  ) u_disp_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (disp_dvd_r),
    .divisor  (DISP_DIV),
    .busy     (disp_busy),
    .quotient (disp_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_beat_has_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[21] |-> out_data_r[29:22] != '0)
    else $error("beat reported with zero rate");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_DIFF)
    else $error("accepted sample did not start processing");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_OUT) |-> !rate_busy && !disp_busy)
    else $error("divider busy outside division phase");

  a_seed_once: assert property (@(posedge clk) disable iff (!rst_n)
    !first_pending_r |=> !first_pending_r)
    else $error("baseline seed flag set again");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrap flag cleared");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ECG baseline beat and rate detector against a cycle-free
// predictor of baseline tracking, beat crossing, rate window and display
// scaling. It runs a directed sequence at reset settings, then phases of
// synthetic ECG traces with dips, spikes, noise and time stamp wraps under
// several register settings and randomized stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import ecgbd_pkg::*;

  localparam int unsigned RING_SLOTS   = RING_DEPTH_DEF;
  localparam int          DRAIN_CYCLES = 48;
  localparam int          LONG_HOLD    = 600;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam longint      ROUND_HALF   = 32768;
  localparam int          N_PHASES     = 7;

  typedef struct packed {
    logic [TIME_W-1:0]   time_ms;
    logic [SAMPLE_W-1:0] adc_sample;
  } ecg_sample_t;

  typedef struct packed {
    logic [4:0]              pad;
    logic                    buffer_filled;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic [DISP_W-1:0]       display_sample;
    logic [RATE_W-1:0]       heart_rate_bpm;
    logic                    beat_detected;
    logic signed [FILT_W-1:0] filtered_value;
  } ecg_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [55:0]           out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // detector settings and state as the predictor sees them
  logic signed [THR_W-1:0] thr_cfg = THR_RST;
  logic [REFR_W-1:0]       refr_cfg = REFR_RST;
  logic [RATE_W-1:0]       min_cfg = MIN_RATE_RST;
  logic [RATE_W-1:0]       max_cfg = MAX_RATE_RST;
  logic [BASE_W-1:0]       base_q = '0;
  logic                    seed_pending = 1'b1;
  logic [TIME_W-1:0]       last_beat_ms = '0;
  logic [RATE_W-1:0]       rate_held = '0;
  logic [SLOT_OUT_W-1:0]   slot_next = '0;
  logic                    ring_wrapped = 1'b0;

  ecg_sample_t queued_samples[$];
  ecg_result_t predicted_results[$];
  ecg_sample_t offered;

  int send_idle_pct = 9;
  int recv_idle_pct = 64;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int error_count = 0;
  int cycle_count = 0;
  int stim_level = 2048;
  logic [TIME_W-1:0] stim_time = 32'h0000_1000;

  ecg_baseline_beat_rate_detector_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // adc_sample[11:0], time_ms[43:12]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // filtered_value[20:0], beat_detected[21], heart_rate_bpm[29:22],
    // display_sample[41:30], slot_index[49:42], buffer_filled[50]
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic ecg_result_t predict_ecg_step(logic [SAMPLE_W-1:0] adc,
                                                   logic [TIME_W-1:0] now);
    longint      target;
    longint      diff;
    longint      filt;
    longint      t;
    longint      scaled;
    logic [31:0] interval;
    logic [31:0] rate;
    ecg_result_t res;
    res = '0;
    target = longint'(adc) <<< 16;
    if (seed_pending) begin
      base_q = target[BASE_W-1:0];
      seed_pending = 1'b0;
    end
    diff = target - longint'(base_q);
    diff = (diff * longint'(WEIGHT_Q16) + ROUND_HALF) >>> 16;
    base_q = BASE_W'(longint'(base_q) + diff);
    filt = (target - longint'(base_q)) >>> 8;
    interval = now - last_beat_ms;
    if (filt < (longint'(thr_cfg) <<< 8) && interval > 32'(refr_cfg)) begin
      last_beat_ms = now;
      rate = (interval != 0) ? 32'(RATE_NUM) / interval : 32'(RATE_NUM);
      if (rate > 32'(min_cfg) && rate < 32'(max_cfg)) begin
        rate_held = rate[RATE_W-1:0];
        res.beat_detected = 1'b1;
      end
    end
    t = filt + longint'(DISP_OFFSET);
    if (t <= 0) begin
      res.display_sample = '0;
    end else begin
      scaled = (t * 2) / longint'(DISP_DIV);
      res.display_sample = (scaled > longint'(DISP_MAX)) ? DISP_MAX : DISP_W'(scaled);
    end
    res.slot_index = slot_next;
    if (int'(slot_next) + 1 >= RING_SLOTS) begin
      slot_next = '0;
      ring_wrapped = 1'b1;
    end else begin
      slot_next = slot_next + 1'b1;
    end
    res.filtered_value = filt[FILT_W-1:0];
    res.heart_rate_bpm = rate_held;
    res.buffer_filled = ring_wrapped;
    return res;
  endfunction

  function automatic void push_sample(int adc, logic [TIME_W-1:0] ms);
    ecg_sample_t s;
    s.adc_sample = SAMPLE_W'(adc);
    s.time_ms = ms;
    queued_samples.push_back(s);
  endfunction

  // synthetic trace: wandering baseline with beats as dips, some spikes,
  // some samples of pure noise and an occasional jump to just before wrap
  task automatic queue_ecg_run(int count);
    int kind;
    int adc;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if ($urandom_range(199) == 0) begin
        stim_time = 32'hFFFF_FFFF - $urandom_range(3000);
      end
      if (kind < 8) begin
        push_sample($urandom_range(4095), $urandom);
      end else begin
        if (kind < 10) begin
          stim_level = $urandom_range(3800, 300);
          adc = stim_level;
        end else if (kind < 22) begin
          adc = stim_level - int'($urandom_range(2500, 150));
        end else if (kind < 26) begin
          adc = stim_level + int'($urandom_range(2500, 200));
        end else begin
          adc = stim_level + int'($urandom_range(80)) - 40;
        end
        if (adc < 0) adc = 0;
        if (adc > 4095) adc = 4095;
        stim_time = stim_time + $urandom_range(260, 1);
        push_sample(adc, stim_time);
      end
    end
  endtask

  task automatic wait_until_drained();
    while (queued_samples.size() != 0 || in_tvalid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_detector(int thr, int refr, int lo, int hi);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_BEAT_THRESHOLD, REG_REFRACTORY_MS, REG_MIN_RATE_BPM, REG_MAX_RATE_BPM};
    val = '{CFG_DATA_W'(thr), CFG_DATA_W'(refr), CFG_DATA_W'(lo), CFG_DATA_W'(hi)};
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    thr_cfg = THR_W'(thr);
    refr_cfg = REFR_W'(refr);
    min_cfg = RATE_W'(lo);
    max_cfg = RATE_W'(hi);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(predict_ecg_step(offered.adc_sample, offered.time_ms));
      end
      if (!in_tvalid || in_tready) begin
        if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, offered};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ecg_result_t got;
    ecg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (predicted_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result transaction: %h", out_tdata);
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        if (got !== want) begin
          if (error_count < 10) begin
            $display("mismatch: expected filt=%0d beat=%0b rate=%0d disp=%0d slot=%0d full=%0b pad=%h",
                     want.filtered_value, want.beat_detected, want.heart_rate_bpm,
                     want.display_sample, want.slot_index, want.buffer_filled, want.pad);
            $display("          actual   filt=%0d beat=%0b rate=%0d disp=%0d slot=%0d full=%0b pad=%h",
                     got.filtered_value, got.beat_detected, got.heart_rate_bpm,
                     got.display_sample, got.slot_index, got.buffer_filled, got.pad);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int phase_thr   [N_PHASES] = '{-200, -4096, 0, -50, 4095, -1000, -1};
    int phase_refr  [N_PHASES] = '{400, 65535, 0, 200, 300, 500, 1000};
    int phase_min   [N_PHASES] = '{40, 0, 0, 100, 255, 30, 20};
    int phase_max   [N_PHASES] = '{160, 255, 255, 101, 0, 200, 250};
    int phase_items [N_PHASES] = '{300, 150, 250, 150, 100, 250, 250};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // seed, extremes, refractory edge, rate window edges, time wrap, backward time
    push_sample(2048, 32'd0);
    push_sample(4095, 32'd4);
    push_sample(0, 32'd8);
    push_sample(2048, 32'd300);
    push_sample(0, 32'd500);
    push_sample(2048, 32'd700);
    push_sample(0, 32'd900);
    push_sample(2048, 32'd950);
    push_sample(0, 32'd1275);
    push_sample(2048, 32'd1300);
    push_sample(0, 32'd1650);
    push_sample(2048, 32'd1700);
    push_sample(0, 32'd3150);
    push_sample(2048, 32'd3200);
    push_sample(0, 32'd3551);
    push_sample(2048, 32'hFFFF_FE00);
    push_sample(0, 32'hFFFF_FF00);
    push_sample(2048, 32'hFFFF_FFFF);
    push_sample(0, 32'h0000_0190);
    push_sample(2048, 32'h0000_0200);
    push_sample(0, 32'h0000_0010);
    push_sample(4095, 32'h0000_0400);
    push_sample(0, 32'h0000_0500);
    wait_until_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      program_detector(phase_thr[p], phase_refr[p], phase_min[p], phase_max[p]);
      if (p == 2) begin
        send_idle_pct = 64;
        recv_idle_pct = 9;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_ecg_run(phase_items[p]);
      if (p == 0) hold_requests++;
      wait_until_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
